[rtl/double_ended_queue_core_macros.svh]
// ----------------------------------------------------------------------------
// Deque core assertion macros
// Concurrent check wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// check that is masked while reset is held
`define DQC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deque core check failed");
// check that also runs through reset
`define DQC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("deque core reset check failed");
`else
`define DQC_ASSERT(lbl, prop)
`define DQC_ASSERT_RST(lbl, prop)
`endif

`endif

[rtl/dqc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque core package
// Request and status codes, control states and the cell chain control word.
// ----------------------------------------------------------------------------
package dqc_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_BACK  = 3'd5,
        REQ_SEARCH     = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SEARCH,
        ST_EXEC
    } state_t;

    // which end of the deque sits at a fixed end cell of the chain
    typedef enum logic {
        MODE_BACK,
        MODE_FRONT
    } mode_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_UP,
        SH_DOWN
    } shift_t;

    typedef struct packed {
        shift_t shift;
        logic   insert;
    } chain_ctrl_t;

endpackage

[rtl/dqc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque chain cell
// One entry register; takes the word of its lower or upper neighbor on a shift.
// ----------------------------------------------------------------------------
module dqc_cell
    import dqc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  chain_ctrl_t            chain_ctrl,
    input  logic [VALUE_WIDTH-1:0] lo_in,
    input  logic [VALUE_WIDTH-1:0] hi_in,
    output logic [VALUE_WIDTH-1:0] data_out
);

    logic [VALUE_WIDTH-1:0] data_reg;

    always_ff @(posedge aclk) begin
        case (chain_ctrl.shift)
            SH_UP:   data_reg <= lo_in;
            SH_DOWN: data_reg <= hi_in;
            default: data_reg <= data_reg;
        endcase
    end

    assign data_out = data_reg;

endmodule

[rtl/dqc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque core controller
// Request decode, ring rotation sequencing, search walk and result register.
// ----------------------------------------------------------------------------
module dqc_ctrl
    import dqc_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_req_type,
    input  logic [VALUE_WIDTH-1:0]       s_item_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [VALUE_WIDTH-1:0]       m_out_value,
    output logic [$clog2(DEPTH)-1:0]     m_match_pos,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill_count,
    input  logic [VALUE_WIDTH-1:0]       tap_back,
    input  logic [VALUE_WIDTH-1:0]       tap_front,
    output chain_ctrl_t                  chain_ctrl,
    output logic [VALUE_WIDTH-1:0]       ins_value
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       step_reg, step_next;
    req_t                   req_reg, req_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                ostat_reg, ostat_next;
    logic [VALUE_WIDTH-1:0] oval_reg, oval_next;
    logic [IDX_W-1:0]       opos_reg, opos_next;
    logic [CNT_W-1:0]       ofill_reg, ofill_next;

    req_t  req_in;
    logic  is_empty, is_full, last_step, out_free;
    logic  in_front, in_acts, in_search_go;
    mode_t in_mode, mode_flip;
    logic  hit;

    assign req_in    = req_t'(s_req_type);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_CNT);
    assign last_step = (step_reg == count_reg - CNT_W'(1));
    assign out_free  = !m_valid_reg || m_ready;
    assign mode_flip = (mode_reg == MODE_BACK) ? MODE_FRONT : MODE_BACK;
    assign hit       = ((mode_reg == MODE_BACK) ? tap_back : tap_front) == val_reg;
    assign in_mode   = in_front ? MODE_FRONT : MODE_BACK;
    assign in_search_go = (req_in == REQ_SEARCH) && (s_item_value != '0) &&
                          !s_item_value[VALUE_WIDTH-1] && !is_empty;

    // request decode: which end a request works on, and whether it is refused
    always_comb begin
        in_front = 1'b0;
        in_acts  = 1'b0;
        unique case (req_in) inside
            REQ_PUSH_FRONT: begin
                in_front = 1'b1;
                in_acts  = !is_full;
            end
            REQ_PUSH_BACK: begin
                in_acts = !is_full;
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                in_front = 1'b1;
                in_acts  = !is_empty;
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
                in_acts = !is_empty;
            end
            default: begin
                in_acts = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (in_search_go) begin
                        state_next = ST_SEARCH;
                    end else if (in_acts && !is_empty && (mode_reg != in_mode)) begin
                        state_next = ST_ROTATE;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_ROTATE, ST_SEARCH: begin
                if (last_step) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        chain_ctrl   = '{shift: SH_HOLD, insert: 1'b0};
        mode_next    = mode_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        req_next     = req_reg;
        val_next     = val_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ostat_next   = ostat_reg;
        oval_next    = oval_reg;
        opos_next    = opos_reg;
        ofill_next   = ofill_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = req_in;
                    val_next   = s_item_value;
                    step_next  = '0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    // empty ring: face the end the push works on, no rotation
                    if (in_acts && is_empty) begin
                        mode_next = in_mode;
                    end
                end
            end
            ST_ROTATE: begin
                chain_ctrl.shift = (mode_reg == MODE_BACK) ? SH_DOWN : SH_UP;
                step_next = step_reg + CNT_W'(1);
                if (last_step) begin
                    mode_next = mode_flip;
                end
            end
            ST_SEARCH: begin
                // back mode walks back to front, front mode walks front to back
                chain_ctrl.shift = (mode_reg == MODE_BACK) ? SH_DOWN : SH_UP;
                step_next = step_reg + CNT_W'(1);
                if (hit) begin
                    if (mode_reg == MODE_BACK) begin
                        if (!found_reg) begin
                            found_next = 1'b1;
                            pos_next   = step_reg[IDX_W-1:0];
                        end
                    end else begin
                        found_next = 1'b1;
                        pos_next   = IDX_W'(count_reg - CNT_W'(1) - step_reg);
                    end
                end
                if (last_step) begin
                    mode_next = mode_flip;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ostat_next   = STAT_OK;
                    oval_next    = '0;
                    opos_next    = '0;
                    unique case (req_reg) inside
                        REQ_PUSH_FRONT: begin
                            if (is_full) begin
                                ostat_next = STAT_FULL;
                            end else begin
                                chain_ctrl = '{shift: SH_DOWN, insert: 1'b1};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_PUSH_BACK: begin
                            if (is_full) begin
                                ostat_next = STAT_FULL;
                            end else begin
                                chain_ctrl = '{shift: SH_UP, insert: 1'b1};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                            if (is_empty) begin
                                ostat_next = STAT_EMPTY;
                            end else begin
                                oval_next = tap_front;
                                if (req_reg == REQ_POP_FRONT) begin
                                    chain_ctrl.shift = SH_UP;
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        REQ_POP_BACK, REQ_PEEK_BACK: begin
                            if (is_empty) begin
                                ostat_next = STAT_EMPTY;
                            end else begin
                                oval_next = tap_back;
                                if (req_reg == REQ_POP_BACK) begin
                                    chain_ctrl.shift = SH_DOWN;
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        REQ_SEARCH: begin
                            if (found_reg) begin
                                oval_next = val_reg;
                                opos_next = pos_reg;
                            end else begin
                                ostat_next = STAT_NOTFOUND;
                            end
                        end
                        default: begin
                            ostat_next = STAT_OK;
                        end
                    endcase
                    ofill_next = count_next;
                end
            end
            default: begin
                chain_ctrl = '{shift: SH_HOLD, insert: 1'b0};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_BACK;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        req_reg   <= req_next;
        val_reg   <= val_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        ostat_reg <= ostat_next;
        oval_reg  <= oval_next;
        opos_reg  <= opos_next;
        ofill_reg <= ofill_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = ostat_reg;
    assign m_out_value  = oval_reg;
    assign m_match_pos  = opos_reg;
    assign m_fill_count = ofill_reg;
    assign ins_value    = val_reg;

endmodule

[rtl/double_ended_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed words held in a rotating chain of cells.
// ----------------------------------------------------------------------------
// The entries live in a ring of DEPTH cells that shift together, one cell per
// clock. Either the back-most entry sits in cell 0 or the front-most entry
// sits in the last cell; a request at the end that is in place is accepted and
// then executed. A request at the other end that is carried out first rotates
// the ring by the fill count, and the next request at that same end needs no
// rotation; a push refused as full does not rotate. A search walks every held
// entry past the end cell and leaves the ring facing the other end; a search
// for a value that is zero or negative, or of an empty deque, does no walk.
// Every request gives one result word, held in an output register so the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core
    import dqc_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_req_type,
    input  logic signed [VALUE_WIDTH-1:0]     s_item_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic signed [VALUE_WIDTH-1:0]     m_out_value,
    output logic [$clog2(DEPTH)-1:0]          m_match_pos,
    output logic [$clog2(DEPTH+1)-1:0]        m_fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    chain_ctrl_t            chain_ctrl;
    logic [VALUE_WIDTH-1:0] ins_value;
    logic [VALUE_WIDTH-1:0] out_value;
    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_lo   [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_hi   [DEPTH];

    dqc_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_item_value ($unsigned(s_item_value)),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_value  (out_value),
        .m_match_pos  (m_match_pos),
        .m_fill_count (m_fill_count),
        .tap_back     (cell_data[0]),
        .tap_front    (cell_data[DEPTH-1]),
        .chain_ctrl   (chain_ctrl),
        .ins_value    (ins_value)
    );

    assign m_out_value = $signed(out_value);

    // end cells either close the ring or take the pushed word
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_lo_end
                assign cell_lo[gi] = chain_ctrl.insert ? ins_value : cell_data[DEPTH-1];
            end else begin : g_lo_mid
                assign cell_lo[gi] = cell_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_hi_end
                assign cell_hi[gi] = chain_ctrl.insert ? ins_value : cell_data[0];
            end else begin : g_hi_mid
                assign cell_hi[gi] = cell_data[gi+1];
            end

            dqc_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .chain_ctrl (chain_ctrl),
                .lo_in      (cell_lo[gi]),
                .hi_in      (cell_hi[gi]),
                .data_out   (cell_data[gi])
            );
        end
    endgenerate

    `DQC_ASSERT_RST(a_reset_clears, !aresetn |=> (!m_valid && s_ready))
    `DQC_ASSERT(a_full_count, (m_valid && (m_status == STAT_FULL)) |-> (m_fill_count == CNT_W'(DEPTH)))
    `DQC_ASSERT(a_empty_count, (m_valid && (m_status == STAT_EMPTY)) |-> (m_fill_count == '0))
    `DQC_ASSERT(a_no_accept_while_shifting, (chain_ctrl.shift != SH_HOLD) |-> !s_ready)

endmodule

[bench/double_ended_queue_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop, peek and search requests into the deque core. Each request
// is predicted on a shadow ring when it is accepted. Each result word is
// checked field by field against the oldest prediction. The run covers
// directed empty, full and search cases first, then biased random traffic
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
    import dqc_pkg::*;

    localparam int DEPTH  = 16;
    localparam int VW     = 32;
    localparam int POS_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct {
        status_t           status;
        logic [VW-1:0]     value;
        logic [POS_W-1:0]  pos;
        logic [FILL_W-1:0] fill;
    } deque_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid;
    logic                     s_ready;
    logic [2:0]               s_req_type;
    logic signed [VW-1:0]     s_item_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [1:0]               m_status;
    logic signed [VW-1:0]     m_out_value;
    logic [POS_W-1:0]         m_match_pos;
    logic [FILL_W-1:0]        m_fill_count;

    // shadow of the deque
    logic [VW-1:0] ring_words [DEPTH];
    int            front_slot = 0;
    int            back_slot = 0;
    int            held_count = 0;

    deque_result_t expected_results [$];
    int            mismatch_count = 0;
    bit            idle_on = 1'b1;

    int            words_sent = 0;
    int            full_refusals = 0;
    int            empty_refusals = 0;
    int            search_hits = 0;
    int            search_misses = 0;
    int            peak_fill = 0;

    logic [VW-1:0] extreme_words [5] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                                         32'hffff_ffff, 32'h0000_0001};

    double_ended_queue_core #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VW)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_value  (m_out_value),
        .m_match_pos  (m_match_pos),
        .m_fill_count (m_fill_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the shadow ring and return the result it yields.
    function automatic deque_result_t apply_request(input logic [2:0] req,
                                                    input logic [VW-1:0] val);
        deque_result_t r;
        int            slot;
        r.status = STAT_OK;
        r.value  = '0;
        r.pos    = '0;
        case (req)
            REQ_PUSH_FRONT: begin
                if (held_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    ring_words[front_slot] = val;
                    front_slot = (front_slot + 1) % DEPTH;
                    held_count++;
                end
            end
            REQ_PUSH_BACK: begin
                if (held_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    back_slot = (back_slot + DEPTH - 1) % DEPTH;
                    ring_words[back_slot] = val;
                    held_count++;
                end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                if (held_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    slot = (front_slot + DEPTH - 1) % DEPTH;
                    r.value = ring_words[slot];
                    if (req == REQ_POP_FRONT) begin
                        front_slot = slot;
                        held_count--;
                    end
                end
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
                if (held_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.value = ring_words[back_slot];
                    if (req == REQ_POP_BACK) begin
                        back_slot = (back_slot + 1) % DEPTH;
                        held_count--;
                    end
                end
            end
            REQ_SEARCH: begin
                r.status = STAT_NOTFOUND;
                // only positive values are looked up; walk from the back end
                if ($signed(val) > 0) begin
                    slot = back_slot;
                    for (int i = 0; i < held_count; i++) begin
                        if (r.status == STAT_NOTFOUND && ring_words[slot] == val) begin
                            r.status = STAT_OK;
                            r.value  = val;
                            r.pos    = POS_W'(i);
                        end
                        slot = (slot + 1) % DEPTH;
                    end
                end
            end
            default: ;
        endcase
        r.fill = FILL_W'(held_count);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Send one request word; predict it at the edge where it is taken.
    task automatic send_word(input logic [2:0] req, input logic [VW-1:0] val);
        int            gap;
        deque_result_t exp_r;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_item_value <= val;
        do @(posedge aclk); while (!s_ready);
        exp_r = apply_request(req, val);
        expected_results.push_back(exp_r);
        words_sent++;
        if (exp_r.status == STAT_FULL) full_refusals++;
        if (exp_r.status == STAT_EMPTY) empty_refusals++;
        if (req == REQ_SEARCH && exp_r.status == STAT_OK) search_hits++;
        if (exp_r.status == STAT_NOTFOUND) search_misses++;
        if (held_count > peak_fill) peak_fill = held_count;
    endtask

    // Hold the input channel until every pending result has come back.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
    endtask

    function automatic logic [VW-1:0] random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return VW'($urandom_range(1, 8));
        if (r < 55) return extreme_words[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    // Mostly look for a value that is held, so searches reach deep positions.
    function automatic logic [VW-1:0] search_word();
        int r;
        r = $urandom_range(0, 99);
        if (held_count != 0 && r < 65)
            return ring_words[(back_slot + $urandom_range(0, held_count - 1)) % DEPTH];
        return random_word();
    endfunction

    function automatic logic [2:0] random_request(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        r = $urandom_range(0, 99);
        if (r < 2) return REQ_UNUSED;
        if (r < 27) return REQ_SEARCH;
        if (r < 42) return $urandom_range(0, 1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
        return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    endfunction

    task automatic test_empty_ring();
        send_word(REQ_POP_FRONT, $urandom);
        send_word(REQ_POP_BACK, $urandom);
        send_word(REQ_PEEK_FRONT, $urandom);
        send_word(REQ_SEARCH, 32'h0000_0001);
    endtask

    task automatic test_full_ring();
        logic [VW-1:0] fill_words [16];
        fill_words = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                       32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h7fff_ffff,
                       32'h0000_0002, 32'h1234_5678, 32'hfedc_ba98, 32'h0000_0001,
                       32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0003, 32'h4000_0000};
        for (int i = 0; i < 16; i++)
            send_word((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, fill_words[i]);
        send_word(REQ_PUSH_FRONT, 32'h0000_0009);
        send_word(REQ_PUSH_BACK, 32'h0000_0009);
        send_word(REQ_PEEK_FRONT, $urandom);
        send_word(REQ_PEEK_BACK, $urandom);
        send_word(REQ_UNUSED, $urandom);
    endtask

    // Duplicates are held, so the first match from the back end must win.
    task automatic test_search_cases();
        send_word(REQ_SEARCH, 32'h7fff_ffff);
        send_word(REQ_SEARCH, 32'h0000_0000);
        send_word(REQ_SEARCH, 32'hffff_ffff);
        send_word(REQ_SEARCH, 32'h8000_0000);
    endtask

    task automatic test_random_traffic(input int n_words);
        int            sent;
        int            k;
        int            push_pct;
        logic [2:0]    req;
        logic [VW-1:0] val;
        sent = 0;
        k = 0;
        while (sent < n_words) begin
            // alternate fill-heavy, drain-heavy and balanced phases
            case ((k / 90) % 3)
                0:       push_pct = 75;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            idle_on = !(k >= 300 && k < 420);
            if (k == 450) hold_until_drained();
            req = random_request(push_pct);
            if (req == REQ_SEARCH) val = search_word();
            else if (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) val = random_word();
            else val = $urandom;
            send_word(req, val);
            if (req != REQ_UNUSED) sent++;
            k++;
        end
        idle_on = 1'b1;
    endtask

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, 13) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : result_check
        deque_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with no request pending");
            end else begin
                exp_r = expected_results.pop_front();
                if (m_status !== exp_r.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_status, exp_r.status));
                if (m_out_value !== exp_r.value)
                    report_mismatch($sformatf("out_value got %h want %h",
                                              m_out_value, exp_r.value));
                if (m_match_pos !== exp_r.pos)
                    report_mismatch($sformatf("match_pos got %0d want %0d",
                                              m_match_pos, exp_r.pos));
                if (m_fill_count !== exp_r.fill)
                    report_mismatch($sformatf("fill_count got %0d want %0d",
                                              m_fill_count, exp_r.fill));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        s_valid      = 1'b0;
        s_req_type   = REQ_PUSH_FRONT;
        s_item_value = '0;
        foreach (ring_words[i]) ring_words[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_ring();
        test_full_ring();
        test_search_cases();
        test_random_traffic(900);
        hold_until_drained();

        $display("Sent %0d requests, peak fill %0d of %0d, %0d mismatches.",
                 words_sent, peak_fill, DEPTH, mismatch_count);
        $display("Refusals: %0d full, %0d empty; searches: %0d hits, %0d misses.",
                 full_refusals, empty_refusals, search_hits, search_misses);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
